[hdl/dfhe_pkg.sv]
package dfhe_pkg;

    localparam int unsigned LEN_SYMS  = 29;
    localparam int unsigned DIST_SYMS = 30;

    localparam logic [7:0] LIT_SPLIT     = 8'd144;
    localparam logic [7:0] LIT_LOW_BASE  = 8'b0011_0000;
    localparam logic [8:0] LIT_HIGH_BASE = 9'h190;
    localparam logic [7:0] LEN_HIGH_BASE = 8'b1100_0000;
    localparam logic [4:0] LEN_HIGH_IDX  = 5'd23;
    localparam logic [8:0] MIN_MATCH     = 9'd3;
    localparam logic [8:0] MAX_MATCH     = 9'd258;
    localparam logic [3:0] MIN_WLOG2     = 4'd8;
    localparam logic [3:0] RESET_WLOG2   = 4'd15;

    localparam logic [4:0] HEADER_COUNT = 5'd3;
    localparam logic [4:0] EOB_COUNT    = 5'd7;

    typedef enum logic [1:0] {
        CMD_HEADER  = 2'd0,
        CMD_LITERAL = 2'd1,
        CMD_MATCH   = 2'd2,
        CMD_EOB     = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [30:0] code_bits;
        logic [4:0]  code_count;
        logic        bad_token;
    } t_result;

    typedef logic [8:0]  t_len_base  [LEN_SYMS];
    typedef logic [2:0]  t_len_extra [LEN_SYMS];
    typedef logic [14:0] t_dist_base [DIST_SYMS];
    typedef logic [3:0]  t_dist_extra[DIST_SYMS];

    localparam t_len_base LEN_BASE = '{
        9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15, 9'd17,
        9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67, 9'd83, 9'd99,
        9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258
    };
    localparam t_len_extra LEN_EXTRA = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd0
    };
    localparam t_dist_base DIST_BASE = '{
        15'd1, 15'd2, 15'd3, 15'd4, 15'd5, 15'd7, 15'd9, 15'd13, 15'd17, 15'd25,
        15'd33, 15'd49, 15'd65, 15'd97, 15'd129, 15'd193, 15'd257, 15'd385,
        15'd513, 15'd769, 15'd1025, 15'd1537, 15'd2049, 15'd3073, 15'd4097,
        15'd6145, 15'd8193, 15'd12289, 15'd16385, 15'd24577
    };
    localparam t_dist_extra DIST_EXTRA = '{
        4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
        4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10,
        4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13
    };

    function automatic logic [4:0] len_index(logic [8:0] len);
        logic [4:0] idx;
        idx = '0;
        for (int i = 0; i < LEN_SYMS; i++) begin
            if (LEN_BASE[i] <= len) begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [4:0] dist_index(logic [15:0] distance);
        logic [4:0] idx;
        idx = '0;
        for (int i = 0; i < DIST_SYMS; i++) begin
            if ({1'b0, DIST_BASE[i]} <= distance) begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [4:0] rev5(logic [4:0] v);
        logic [4:0] r;
        for (int i = 0; i < 5; i++) begin
            r[i] = v[4 - i];
        end
        return r;
    endfunction

    function automatic logic [6:0] rev7(logic [6:0] v);
        logic [6:0] r;
        for (int i = 0; i < 7; i++) begin
            r[i] = v[6 - i];
        end
        return r;
    endfunction

    function automatic logic [7:0] rev8(logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

    function automatic logic [8:0] rev9(logic [8:0] v);
        logic [8:0] r;
        for (int i = 0; i < 9; i++) begin
            r[i] = v[8 - i];
        end
        return r;
    endfunction

endpackage

[hdl/deflate_fixed_huffman_symbol_encoder.sv]
// channel  handshake          payload
// token    i_valid / o_stall  i_cmd i_final_block i_literal_byte i_match_length i_match_distance
// code     o_valid / i_stall  o_code_bits o_code_count o_bad_token
// config   i_cfg_we           i_cfg_wdata (window_log2)
//
// one token per cycle sustained while i_stall is low: input register, then result register
// the code lookup and bit packing sit in one combinational stage between them
// i_rst_n is synchronous: clears both valid flags and sets window_log2 to 15
// i_stall holds the result register; the input register keeps taking one more token
module deflate_fixed_huffman_symbol_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic        i_final_block,
    input  logic [7:0]  i_literal_byte,
    input  logic [8:0]  i_match_length,
    input  logic [15:0] i_match_distance,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [30:0] o_code_bits,
    output logic [4:0]  o_code_count,
    output logic        o_bad_token,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata
);

    logic [3:0]        r_window_log2;
    logic              r_in_valid;
    dfhe_pkg::t_cmd    r_cmd;
    logic              r_final_block;
    logic [7:0]        r_literal_byte;
    logic [8:0]        r_match_length;
    logic [15:0]       r_match_distance;
    logic              r_out_valid;
    dfhe_pkg::t_result r_out;
    dfhe_pkg::t_result n_out;
    logic              out_advance;

    assign out_advance = !r_out_valid || !i_stall;
    assign o_stall     = r_in_valid && !out_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_log2 <= dfhe_pkg::RESET_WLOG2;
        end else if (i_cfg_we) begin
            r_window_log2 <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_cmd            <= dfhe_pkg::t_cmd'(i_cmd);
            r_final_block    <= i_final_block;
            r_literal_byte   <= i_literal_byte;
            r_match_length   <= i_match_length;
            r_match_distance <= i_match_distance;
        end
    end

    dfhe_encode u_encode (
        .i_cmd            (r_cmd),
        .i_final_block    (r_final_block),
        .i_literal_byte   (r_literal_byte),
        .i_match_length   (r_match_length),
        .i_match_distance (r_match_distance),
        .i_window_log2    (r_window_log2),
        .o_result         (n_out)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_code_bits  = r_out.code_bits;
    assign o_code_count = r_out.code_count;
    assign o_bad_token  = r_out.bad_token;

    a_bad_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.bad_token |-> r_out.code_count == '0 && r_out.code_bits == '0)
        else $error("bad token carries code bits");

    a_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.code_bits >> r_out.code_count) == '0)
        else $error("bits set above code count");

    a_min_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.bad_token |-> r_out.code_count >= dfhe_pkg::HEADER_COUNT)
        else $error("good token with too few bits");

    a_stage_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && out_advance |=> r_out_valid)
        else $error("token lost between stages");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid)
        else $error("stall with free space");

endmodule

[hdl/dfhe_match_code.sv]
module dfhe_match_code (
    input  logic [8:0]       i_match_length,
    input  logic [15:0]      i_match_distance,
    input  logic [3:0]       i_window_log2,
    output dfhe_pkg::t_result o_result
);

    logic [3:0]  wl;
    logic [16:0] wsize;
    logic        len_ok;
    logic        dist_ok;
    logic [4:0]  li;
    logic [4:0]  di;
    logic [7:0]  lcode;
    logic [3:0]  lcnt;
    logic [2:0]  lex;
    logic [8:0]  ldiff;
    logic [3:0]  dex;
    logic [15:0] ddiff;
    logic [4:0]  pos1;
    logic [4:0]  pos2;
    logic [30:0] bits;

    always_comb begin
        wl      = (i_window_log2 < dfhe_pkg::MIN_WLOG2) ? dfhe_pkg::MIN_WLOG2 : i_window_log2;
        wsize   = 17'(1) << wl;
        len_ok  = (i_match_length >= dfhe_pkg::MIN_MATCH) &&
                  (i_match_length <= dfhe_pkg::MAX_MATCH);
        dist_ok = (i_match_distance != '0) && ({1'b0, i_match_distance} <= wsize);

        li = dfhe_pkg::len_index(i_match_length);
        di = dfhe_pkg::dist_index(i_match_distance);

        if (li < dfhe_pkg::LEN_HIGH_IDX) begin
            lcode = {1'b0, dfhe_pkg::rev7(7'(li) + 7'd1)};
            lcnt  = 4'd7;
        end else begin
            lcode = dfhe_pkg::rev8(dfhe_pkg::LEN_HIGH_BASE + 8'(li - dfhe_pkg::LEN_HIGH_IDX));
            lcnt  = 4'd8;
        end

        lex   = dfhe_pkg::LEN_EXTRA[li];
        ldiff = i_match_length - dfhe_pkg::LEN_BASE[li];
        dex   = dfhe_pkg::DIST_EXTRA[di];
        ddiff = i_match_distance - {1'b0, dfhe_pkg::DIST_BASE[di]};

        pos1 = 5'(lcnt) + 5'(lex);
        pos2 = pos1 + 5'd5;
        bits = 31'(lcode)
             | (31'(ldiff[4:0]) << lcnt)
             | (31'(dfhe_pkg::rev5(di)) << pos1)
             | (31'(ddiff[12:0]) << pos2);

        if (len_ok && dist_ok) begin
            o_result.code_bits  = bits;
            o_result.code_count = pos2 + 5'(dex);
            o_result.bad_token  = 1'b0;
        end else begin
            o_result.code_bits  = '0;
            o_result.code_count = '0;
            o_result.bad_token  = 1'b1;
        end
    end

endmodule

[hdl/dfhe_encode.sv]
module dfhe_encode (
    input  dfhe_pkg::t_cmd    i_cmd,
    input  logic              i_final_block,
    input  logic [7:0]        i_literal_byte,
    input  logic [8:0]        i_match_length,
    input  logic [15:0]       i_match_distance,
    input  logic [3:0]        i_window_log2,
    output dfhe_pkg::t_result o_result
);

    dfhe_pkg::t_result match_result;

    dfhe_match_code u_match_code (
        .i_match_length   (i_match_length),
        .i_match_distance (i_match_distance),
        .i_window_log2    (i_window_log2),
        .o_result         (match_result)
    );

    always_comb begin
        o_result = '0;
        unique case (i_cmd)
            dfhe_pkg::CMD_HEADER: begin
                o_result.code_bits  = 31'({2'b01, i_final_block});
                o_result.code_count = dfhe_pkg::HEADER_COUNT;
            end
            dfhe_pkg::CMD_LITERAL: begin
                if (i_literal_byte < dfhe_pkg::LIT_SPLIT) begin
                    o_result.code_bits  = 31'(dfhe_pkg::rev8(dfhe_pkg::LIT_LOW_BASE
                                                           + i_literal_byte));
                    o_result.code_count = 5'd8;
                end else begin
                    o_result.code_bits  = 31'(dfhe_pkg::rev9(dfhe_pkg::LIT_HIGH_BASE
                                          + 9'(i_literal_byte - dfhe_pkg::LIT_SPLIT)));
                    o_result.code_count = 5'd9;
                end
            end
            dfhe_pkg::CMD_MATCH: begin
                o_result = match_result;
            end
            dfhe_pkg::CMD_EOB: begin
                o_result.code_count = dfhe_pkg::EOB_COUNT;
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

endmodule

[dv/deflate_fixed_huffman_symbol_encoder_test.sv]
module deflate_fixed_huffman_symbol_encoder_test;

    class token_code_scoreboard;
        dfhe_pkg::t_result expected_codes[$];
        logic [3:0]        window_log2;
        int unsigned       errors;

        function new();
            window_log2 = dfhe_pkg::RESET_WLOG2;
            errors = 0;
        endfunction

        function void set_window(logic [3:0] value);
            window_log2 = value;
        endfunction

        function int window_span();
            int wl;
            wl = window_log2;
            if (wl < 8) wl = 8;
            if (wl > 15) wl = 15;
            return 1 << wl;
        endfunction

        function bit [31:0] mirror(bit [31:0] v, int n);
            bit [31:0] r;
            r = '0;
            for (int i = 0; i < n; i++) begin
                r[n - 1 - i] = v[i];
            end
            return r;
        endfunction

        // fixed-huffman bits for one token, first bit to send in bit 0
        function dfhe_pkg::t_result fixed_huffman_code(dfhe_pkg::t_cmd cmd, bit fin, int lit,
                                                       int len, int distance);
            dfhe_pkg::t_result res;
            bit [63:0]   acc;
            int          pos;
            int          base;
            int          n;
            int          idx;
            int          len_idx;
            int          len_n;
            int          dist_idx;
            int          dist_n;
            int          sym;
            bit [31:0]   vals[4];
            int          widths[4];
            int          parts;
            acc = '0;
            pos = 0;
            parts = 0;
            res.bad_token = 1'b0;
            case (cmd)
                dfhe_pkg::CMD_HEADER: begin
                    vals[0] = 32'(fin) + 32'd2;
                    widths[0] = 3;
                    parts = 1;
                end
                dfhe_pkg::CMD_LITERAL: begin
                    if (lit < 144) begin
                        vals[0] = mirror(32'h30 + 32'(lit), 8);
                        widths[0] = 8;
                    end else begin
                        vals[0] = mirror(32'h190 + 32'(lit - 144), 9);
                        widths[0] = 9;
                    end
                    parts = 1;
                end
                dfhe_pkg::CMD_EOB: begin
                    vals[0] = '0;
                    widths[0] = 7;
                    parts = 1;
                end
                default: begin
                    if (len < 3 || len > 258 || distance == 0 || distance > window_span()) begin
                        res.bad_token = 1'b1;
                    end else begin
                        len_idx = 28;
                        len_n = 0;
                        base = 3;
                        if (len != 258) begin
                            for (idx = 0; idx < 28; idx++) begin
                                n = (idx < 8) ? 0 : (idx - 4) / 4;
                                if (len < base + (1 << n)) begin
                                    len_idx = idx;
                                    len_n = n;
                                    break;
                                end
                                base += 1 << n;
                            end
                        end else begin
                            base = 258;
                        end
                        sym = 257 + len_idx;
                        if (sym < 280) begin
                            vals[0] = mirror(32'(sym - 256), 7);
                            widths[0] = 7;
                        end else begin
                            vals[0] = mirror(32'hC0 + 32'(sym - 280), 8);
                            widths[0] = 8;
                        end
                        vals[1] = 32'(len - base);
                        widths[1] = len_n;
                        dist_idx = 0;
                        dist_n = 0;
                        base = 1;
                        for (idx = 0; idx < 30; idx++) begin
                            n = (idx < 4) ? 0 : idx / 2 - 1;
                            if (distance < base + (1 << n)) begin
                                dist_idx = idx;
                                dist_n = n;
                                break;
                            end
                            base += 1 << n;
                        end
                        vals[2] = mirror(32'(dist_idx), 5);
                        widths[2] = 5;
                        vals[3] = 32'(distance - base);
                        widths[3] = dist_n;
                        parts = 4;
                    end
                end
            endcase
            for (int p = 0; p < parts; p++) begin
                acc |= (64'(vals[p]) & ((64'd1 << widths[p]) - 64'd1)) << pos;
                pos += widths[p];
            end
            res.code_bits = acc[30:0];
            res.code_count = 5'(pos);
            return res;
        endfunction

        function void note_token(dfhe_pkg::t_cmd cmd, bit fin, int lit, int len,
                                 int distance);
            expected_codes.insert(expected_codes.size(),
                                  fixed_huffman_code(cmd, fin, lit, len, distance));
        endfunction

        function void check_code(dfhe_pkg::t_result got);
            dfhe_pkg::t_result want;
            if (expected_codes.size() == 0) begin
                $error("code transfer with no token pending: bits %h count %0d bad %0d",
                       got.code_bits, got.code_count, got.bad_token);
                errors++;
                return;
            end
            want = expected_codes.pop_front();
            if (got.code_bits !== want.code_bits) begin
                $error("code_bits: expected %h, got %h", want.code_bits, got.code_bits);
                errors++;
            end
            if (got.code_count !== want.code_count) begin
                $error("code_count: expected %0d, got %0d", want.code_count, got.code_count);
                errors++;
            end
            if (got.bad_token !== want.bad_token) begin
                $error("bad_token: expected %0d, got %0d", want.bad_token, got.bad_token);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_cmd = dfhe_pkg::CMD_HEADER;
    logic        i_final_block = 1'b0;
    logic [7:0]  i_literal_byte = '0;
    logic [8:0]  i_match_length = '0;
    logic [15:0] i_match_distance = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [30:0] o_code_bits;
    logic [4:0]  o_code_count;
    logic        o_bad_token;
    logic        i_cfg_we = 1'b0;
    logic [3:0]  i_cfg_wdata = '0;

    token_code_scoreboard sb;
    int burst_left = 1;

    deflate_fixed_huffman_symbol_encoder dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_cmd            (i_cmd),
        .i_final_block    (i_final_block),
        .i_literal_byte   (i_literal_byte),
        .i_match_length   (i_match_length),
        .i_match_distance (i_match_distance),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_code_bits      (o_code_bits),
        .o_code_count     (o_code_count),
        .o_bad_token      (o_bad_token),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    initial begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver stall pattern, switches style every so often
    initial begin
        int mode;
        int mode_left;
        int tick;
        mode = 0;
        mode_left = 0;
        tick = 0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            tick++;
            case (mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                2: i_stall <= ((tick % 7) < 3);
                default: i_stall <= $urandom_range(0, 1);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_code('{o_code_bits, o_code_count, o_bad_token});
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_token(dfhe_pkg::t_cmd cmd, bit fin, bit [7:0] lit, bit [8:0] len,
                              bit [15:0] distance);
        int gap;
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_final_block <= fin;
        i_literal_byte <= lit;
        i_match_length <= len;
        i_match_distance <= distance;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_token(cmd, fin, lit, len, distance);
        @(negedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    task automatic send_match(int len, int distance);
        send_token(dfhe_pkg::CMD_MATCH, 1'($urandom), 8'($urandom), 9'(len), 16'(distance));
    endtask

    task automatic drain_codes();
        i_valid <= 1'b0;
        while (sb.expected_codes.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_window(logic [3:0] value);
        drain_codes();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= 4'($urandom);
        sb.set_window(value);
        @(negedge i_clk);
    endtask

    task automatic random_token();
        int pick;
        int span;
        int len;
        int distance;
        pick = $urandom_range(0, 99);
        span = sb.window_span();
        if ($urandom_range(0, 9) == 0) len = 258;
        else if ($urandom_range(0, 1) == 0) len = $urandom_range(3, 258);
        else len = 3 + ($urandom & ((1 << $urandom_range(1, 7)) - 1));
        if ($urandom_range(0, 15) == 0) distance = span;
        else distance = $urandom_range(1, 1 << $urandom_range(0, $clog2(span)));
        if (pick < 8) begin
            send_token(dfhe_pkg::CMD_HEADER, 1'($urandom), 8'($urandom), 9'($urandom),
                       16'($urandom));
        end else if (pick < 40) begin
            send_token(dfhe_pkg::CMD_LITERAL, 1'($urandom), 8'($urandom), 9'($urandom),
                       16'($urandom));
        end else if (pick < 45) begin
            send_token(dfhe_pkg::CMD_EOB, 1'($urandom), 8'($urandom), 9'($urandom),
                       16'($urandom));
        end else if (pick < 88) begin
            send_match(len, distance);
        end else begin
            case ($urandom_range(0, 3))
                0: send_match($urandom_range(0, 2), distance);
                1: send_match($urandom_range(259, 511), distance);
                2: send_match(len, 0);
                default: send_match(len, $urandom_range(span + 1, 65535));
            endcase
        end
    endtask

    initial begin
        logic [3:0] windows[7];
        sb = new();
        windows = '{4'd8, 4'd0, 4'd13, 4'd15, 4'd7, 4'd10, 4'($urandom)};
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed tokens at the reset window
        send_token(dfhe_pkg::CMD_HEADER, 1'b0, 8'hFF, 9'h1FF, 16'hFFFF);
        send_token(dfhe_pkg::CMD_HEADER, 1'b1, 8'h00, 9'h000, 16'h0000);
        send_token(dfhe_pkg::CMD_LITERAL, 1'b1, 8'd0, 9'h1FF, 16'hFFFF);
        send_token(dfhe_pkg::CMD_LITERAL, 1'b0, 8'd143, 9'h000, 16'h0000);
        send_token(dfhe_pkg::CMD_LITERAL, 1'b1, 8'd144, 9'h155, 16'hAAAA);
        send_token(dfhe_pkg::CMD_LITERAL, 1'b0, 8'd255, 9'h0AA, 16'h5555);
        send_token(dfhe_pkg::CMD_EOB, 1'b1, 8'hA5, 9'h1FF, 16'hFFFF);
        send_match(3, 1);
        send_match(258, 32768);
        send_match(10, 4);
        send_match(11, 5);
        send_match(114, 24576);
        send_match(115, 24577);
        send_match(257, 16384);
        send_match(227, 1);
        send_match(2, 100);
        send_match(0, 100);
        send_match(259, 100);
        send_match(511, 100);
        send_match(100, 0);
        send_match(100, 32769);
        send_match(100, 65535);

        foreach (windows[p]) begin
            write_window(windows[p]);
            send_match(3 + $urandom_range(0, 255), sb.window_span());
            send_match(3 + $urandom_range(0, 255), sb.window_span() + 1);
            repeat (186) random_token();
        end

        drain_codes();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/dfhe_pkg.sv
hdl/dfhe_match_code.sv
hdl/dfhe_encode.sv
hdl/deflate_fixed_huffman_symbol_encoder.sv
dv/deflate_fixed_huffman_symbol_encoder_test.sv
